>>> sv/sdes_cbc_cipher_core_assert.svh
// assertion macros shared by the s-des cbc cipher rtl
// expects clk and rst_n in the scope of each use

`ifndef SDES_CBC_CIPHER_CORE_ASSERT_SVH
`define SDES_CBC_CIPHER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SDES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SDES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sdes_cbc_pkg.sv
// types, register codes and s-des round functions for the cbc cipher
// no dependencies

package sdes_cbc_pkg;

    localparam int unsigned KEY_W   = 10;
    localparam int unsigned BLOCK_W = 8;
    localparam int unsigned CFG_W   = 10;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;
    typedef logic [1:0]         cfg_index_t;

    typedef struct packed {
        block_t k1;
        block_t k2;
    } subkeys_t;

    // configuration register indexes
    localparam cfg_index_t CFG_KEY     = 2'd0;
    localparam cfg_index_t CFG_IV      = 2'd1;
    localparam cfg_index_t CFG_DECRYPT = 2'd2;

    // s-boxes, indexed [row][col]
    localparam logic [1:0] S0_BOX [4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd3, 2'd2}
    };
    localparam logic [1:0] S1_BOX [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    // permutation position 1 is the msb
    function automatic key_t perm_p10(input key_t k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic block_t perm_p8(input key_t k);
        return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
    endfunction

    function automatic block_t perm_ip(input block_t b);
        return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
    endfunction

    function automatic block_t perm_ip_inv(input block_t b);
        return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
    endfunction

    function automatic block_t perm_ep(input logic [3:0] n);
        return {n[0], n[3], n[2], n[1], n[2], n[1], n[0], n[3]};
    endfunction

    function automatic logic [3:0] perm_p4(input logic [3:0] n);
        return {n[2], n[0], n[1], n[3]};
    endfunction

    function automatic subkeys_t make_subkeys(input key_t key);
        key_t       p;
        logic [4:0] hi;
        logic [4:0] lo;
        subkeys_t   sk;
        p     = perm_p10(key);
        hi    = p[9:5];
        lo    = p[4:0];
        sk.k1 = perm_p8({hi[3:0], hi[4], lo[3:0], lo[4]});
        sk.k2 = perm_p8({hi[1:0], hi[4:2], lo[1:0], lo[4:2]});
        return sk;
    endfunction

    function automatic block_t feistel(input block_t b, input block_t sk);
        block_t     e;
        logic [1:0] s0;
        logic [1:0] s1;
        logic [3:0] f;
        e  = perm_ep(b[3:0]) ^ sk;
        s0 = S0_BOX[{e[7], e[4]}][{e[6], e[5]}];
        s1 = S1_BOX[{e[3], e[0]}][{e[2], e[1]}];
        f  = perm_p4({s0, s1});
        return {b[7:4] ^ f, b[3:0]};
    endfunction

    function automatic block_t run_block(input block_t x, input block_t ka,
                                         input block_t kb);
        block_t b;
        b = feistel(perm_ip(x), ka);
        b = feistel({b[3:0], b[7:4]}, kb);
        return perm_ip_inv(b);
    endfunction

endpackage

>>> sv/sdes_cbc_cipher_core.sv
// s-des block cipher on bytes with cbc chaining, one byte per cycle unless out_ready stalls the result
// data path: input stage register, then the combinational cipher, then the registered data_out
// throughput: one byte per cycle while out_ready holds; the chain register closes in the cipher stage
// reset: key, iv, mode, chain register and all valid flags clear to zero
// depends on sdes_cbc_pkg and sdes_cbc_cipher_core_assert.svh

module sdes_cbc_cipher_core
    import sdes_cbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_write,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  block_t     data_in,
    input  logic       start_chain,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output block_t     data_out
);

    // configuration registers
    key_t   cipher_key_reg;
    block_t init_vector_reg;
    logic   decrypt_mode_reg;

    // input stage
    logic   s1_valid_reg;
    block_t s1_data_reg;
    logic   s1_start_reg;

    // cbc chain: always the last ciphertext byte
    block_t chain_reg;
    block_t chain_next;

    // result stage
    logic   out_valid_reg;
    block_t data_out_reg;
    block_t data_out_next;

    logic     s1_adv;
    logic     in_xfer;
    subkeys_t subkeys;
    block_t   chain_val;
    block_t   cipher_in;
    block_t   cipher_out;

    // config must only change while idle (the core does not enforce this), so subkeys can stay combinational
    assign subkeys = make_subkeys(cipher_key_reg);

    // the result register frees when empty or when its byte transfers
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_xfer  = in_valid && in_ready;

    // start of message picks the iv instead of the stored block
    assign chain_val = s1_start_reg ? init_vector_reg : chain_reg;

    // encrypt xors before the cipher, decrypt after it; subkey order flips
    always_comb
    begin
        if (decrypt_mode_reg)
        begin
            cipher_in     = s1_data_reg;
            cipher_out    = run_block(cipher_in, subkeys.k2, subkeys.k1);
            data_out_next = cipher_out ^ chain_val;
            chain_next    = s1_data_reg;
        end
        else
        begin
            cipher_in     = s1_data_reg ^ chain_val;
            cipher_out    = run_block(cipher_in, subkeys.k1, subkeys.k2);
            data_out_next = cipher_out;
            chain_next    = cipher_out;
        end
    end

    // configuration writes; unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg   <= '0;
            init_vector_reg  <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY:     cipher_key_reg   <= cfg_data[KEY_W-1:0];
                CFG_IV:      init_vector_reg  <= cfg_data[BLOCK_W-1:0];
                CFG_DECRYPT: decrypt_mode_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // control flags and chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                chain_reg     <= chain_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg  <= data_in;
            s1_start_reg <= start_chain;
        end
        if (s1_adv)
        begin
            data_out_reg <= data_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

`include "sdes_cbc_cipher_core_assert.svh"

    `SDES_ASSERT_NEXT(a_enc_chain, s1_adv && !decrypt_mode_reg, chain_reg == data_out_reg, "encrypt chain differs from result")
    `SDES_ASSERT_NEXT(a_dec_chain, s1_adv && decrypt_mode_reg, chain_reg == $past(s1_data_reg), "decrypt chain differs from input byte")
    `SDES_ASSERT_NOW(a_empty_ready, !s1_valid_reg, in_ready, "empty input stage not ready")
    `SDES_ASSERT_NEXT(a_adv_valid, s1_adv, out_valid_reg, "advanced byte lost at result stage")

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the s-des cbc cipher core
// predicts every output byte with its own s-des/cbc model and checks each result transfer
// depends on sdes_cbc_pkg and the sdes_cbc_cipher_core rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdes_cbc_pkg::*;

    // permutation maps, position 1 is the msb, unused tail entries are zero
    typedef int perm_map_t [10];

    localparam perm_map_t MAP_P10   = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
    localparam perm_map_t MAP_P8    = '{6, 3, 7, 4, 8, 5, 10, 9, 0, 0};
    localparam perm_map_t MAP_IP    = '{2, 6, 3, 1, 4, 8, 5, 7, 0, 0};
    localparam perm_map_t MAP_IPINV = '{4, 1, 3, 5, 7, 2, 8, 6, 0, 0};
    localparam perm_map_t MAP_EP    = '{4, 1, 2, 3, 2, 3, 4, 1, 0, 0};
    localparam perm_map_t MAP_P4    = '{2, 4, 3, 1, 0, 0, 0, 0, 0, 0};

    // s-boxes flattened as row * 4 + col
    localparam logic [1:0] SBOX_0 [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,  2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,  2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] SBOX_1 [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,  2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,  2'd2, 2'd1, 2'd0, 2'd3
    };

    // index past the end of the register list, the core must ignore it
    localparam cfg_index_t CFG_NONE = 2'd3;

    // idle plans of the random phases, percent of cycles
    localparam int SEND_IDLE  [4] = '{0, 72, 0, 19};
    localparam int RECV_STALL [4] = '{0, 0, 72, 19};

    localparam int PHASE_ITEMS   = 185;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 4;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;
    logic       in_valid;
    logic       in_ready;
    block_t     data_in;
    logic       start_chain;
    logic       out_valid;
    logic       out_ready;
    block_t     data_out;

    // model copy of the registers and the chain byte
    key_t   model_key;
    block_t model_iv;
    logic   model_decrypt;
    block_t model_chain;

    block_t expected_bytes [$];
    int     error_count;
    int     stall_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;

    sdes_cbc_cipher_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_in     (data_in),
        .start_chain (start_chain),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // s-des / cbc prediction
    // ---------------------------------------------------------------

    // output position i takes input position map[i], both counted from the msb
    function automatic logic [9:0] permute_pos(input logic [9:0] src, input int n_in,
                                               input int n_out, input perm_map_t map);
        logic [9:0] r;
        r = '0;
        for (int i = 0; i < n_out; i++)
            r[n_out-1-i] = src[n_in - map[i]];
        return r;
    endfunction

    // circular left rotation of a 5-bit half
    function automatic logic [4:0] rot5_left(input logic [4:0] v, input int k);
        logic [9:0] twice;
        twice = {v, v} >> (5 - k);
        return twice[4:0];
    endfunction

    // k1 from a rotation by one, k2 from a rotation by three in total
    function automatic subkeys_t round_keys(input key_t key);
        logic [9:0] p;
        subkeys_t   sk;
        p     = permute_pos(key, 10, 10, MAP_P10);
        sk.k1 = block_t'(permute_pos({rot5_left(p[9:5], 1), rot5_left(p[4:0], 1)},
                                     10, 8, MAP_P8));
        sk.k2 = block_t'(permute_pos({rot5_left(p[9:5], 3), rot5_left(p[4:0], 3)},
                                     10, 8, MAP_P8));
        return sk;
    endfunction

    // one feistel round: left half xor f(right half, subkey)
    function automatic block_t mix_round(input block_t b, input block_t sk);
        logic [3:0] right;
        logic [3:0] nib_a;
        logic [3:0] nib_b;
        logic [3:0] four;
        logic [3:0] f;
        block_t     e;
        right = b[3:0];
        e     = block_t'(permute_pos({6'd0, right}, 4, 8, MAP_EP)) ^ sk;
        nib_a = e[7:4];
        nib_b = e[3:0];
        // row from the outer bits, column from the inner bits
        four  = {SBOX_0[{nib_a[3], nib_a[0], nib_a[2], nib_a[1]}],
                 SBOX_1[{nib_b[3], nib_b[0], nib_b[2], nib_b[1]}]};
        f     = 4'(permute_pos({6'd0, four}, 4, 4, MAP_P4));
        return {b[7:4] ^ f, right};
    endfunction

    function automatic block_t cipher_byte(input block_t x, input block_t ka,
                                           input block_t kb);
        block_t b;
        b = block_t'(permute_pos({2'd0, x}, 8, 8, MAP_IP));
        b = mix_round(b, ka);
        b = {b[3:0], b[7:4]};
        b = mix_round(b, kb);
        return block_t'(permute_pos({2'd0, b}, 8, 8, MAP_IPINV));
    endfunction

    // next output byte of the cbc stream, advances the model chain byte
    function automatic block_t cbc_next_byte(input block_t value, input logic first);
        block_t   chain;
        block_t   res;
        subkeys_t keys;
        chain = first ? model_iv : model_chain;
        keys  = round_keys(model_key);
        if (model_decrypt)
        begin
            res         = cipher_byte(value, keys.k2, keys.k1) ^ chain;
            model_chain = value;
        end
        else
        begin
            res         = cipher_byte(value ^ chain, keys.k1, keys.k2);
            model_chain = res;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // transfer monitor and result checker
    // ---------------------------------------------------------------

    task automatic record_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%t mismatch: %s", $realtime, what);
    endtask

    // results are popped before the new input is predicted, so a result and an
    // input transfer on the same edge never race on the queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    record_mismatch($sformatf("unexpected result transfer data_out=%02h",
                                              data_out));
                else if (data_out !== expected_bytes[0])
                begin
                    record_mismatch($sformatf("data_out expected %02h got %02h",
                                              expected_bytes[0], data_out));
                    void'(expected_bytes.pop_front());
                end
                else
                    void'(expected_bytes.pop_front());
            end
            if (in_valid && in_ready)
                expected_bytes.push_back(cbc_next_byte(data_in, start_chain));
        end
    end

    // receiver back-pressure, one decision per cycle
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // watchdog: a run of cycles with no transfer and no register write means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // drivers, entered and left just after a falling edge
    // ---------------------------------------------------------------

    // one input transfer; valid only drops when the sender goes idle, so it is
    // never lowered and raised in the same step
    task automatic send_byte(input block_t value, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_in     <= value;
        start_chain <= first;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write; only called while the core is idle
    task automatic set_register(input cfg_index_t idx, input cfg_data_t value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_KEY:     model_key     = value[KEY_W-1:0];
            CFG_IV:      model_iv      = value[BLOCK_W-1:0];
            CFG_DECRYPT: model_decrypt = value[0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_config(input cfg_data_t key, input cfg_data_t iv,
                               input cfg_data_t mode);
        set_register(CFG_KEY, key);
        set_register(CFG_IV, iv);
        set_register(CFG_DECRYPT, mode);
    endtask

    // messages that open with a start flag and chain on (with continue_chain the first one chains
    // on from before), with a few noisy ones where the start flag lands at random
    task automatic send_messages(input int count, input bit continue_chain);
        int  sent;
        int  len;
        bit  noisy;
        sent = 0;
        while (sent < count)
        begin
            len   = $urandom_range(1, 12);
            noisy = ($urandom_range(0, 9) == 0);
            for (int j = 0; j < len; j++)
            begin
                if (noisy)
                    send_byte(block_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    send_byte(block_t'($urandom_range(0, 255)),
                              (j == 0) && !(continue_chain && sent == 0));
            end
            sent += len;
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // registers at reset, no start flag: chaining starts from the zero chain byte
    task automatic test_after_reset();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        wait_idle();
    endtask

    // all-ones then all-zero key and iv, extreme data bytes, start flag both ways
    task automatic test_field_extremes();
        load_config(10'h3FF, 10'h0FF, 10'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
        load_config(10'h000, 10'h000, 10'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_idle();
    endtask

    // decrypt a short message with an iv
    task automatic test_decrypt();
        load_config(10'h282, 10'h0A5, 10'd1);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_idle();
    endtask

    // switch mode mid-message: the chain byte carries over into the new mode
    task automatic test_mode_switch();
        load_config(10'h155, 10'h033, 10'd0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        wait_idle();
        set_register(CFG_DECRYPT, 10'd1);
        send_byte(8'h56, 1'b0);
        wait_idle();
        set_register(CFG_DECRYPT, 10'd0);
        send_byte(8'h78, 1'b0);
        wait_idle();
    endtask

    // writes to an unused index are dropped, bits above a register width are masked
    task automatic test_config_corners();
        load_config(10'h2AA, 10'h3C7, 10'h3FE);
        set_register(CFG_NONE, 10'h3FF);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        wait_idle();
        set_register(CFG_DECRYPT, 10'h201);
        send_byte(8'hE1, 1'b0);
        wait_idle();
    endtask

    // random messages under each idle plan, random registers per phase and a
    // mode flip halfway that keeps the chain going
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            load_config(cfg_data_t'($urandom_range(0, 1023)),
                        cfg_data_t'($urandom_range(0, 1023)),
                        cfg_data_t'($urandom_range(0, 1023)));
            send_messages(PHASE_ITEMS / 2, 1'b0);
            wait_idle();
            set_register(CFG_DECRYPT, cfg_data_t'(!model_decrypt));
            send_messages(PHASE_ITEMS / 2, 1'b1);
            wait_idle();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_KEY;
        cfg_data       = '0;
        in_valid       = 1'b0;
        data_in        = '0;
        start_chain    = 1'b0;
        out_ready      = 1'b0;
        model_key      = '0;
        model_iv       = '0;
        model_decrypt  = 1'b0;
        model_chain    = '0;
        error_count    = 0;
        stall_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_after_reset();
        test_field_extremes();
        test_decrypt();
        test_mode_switch();
        test_config_corners();
        test_random_traffic();

        // all stimulus is in and drained; let the pipeline settle before the final check
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
